FILE: rtl/led_ring_pattern_sequencer_defines.svh
// Assertion macros for the LED ring pattern sequencer.
// Taken in by the top level; needs a signal named clock and one named reset.
`ifndef LED_RING_PATTERN_SEQUENCER_DEFINES_SVH
`define LED_RING_PATTERN_SEQUENCER_DEFINES_SVH

// cond holds at every edge outside reset
`define LRPS_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("lrps: invariant violated");

// trig implies cond in the same cycle
`define LRPS_ASSERT_IMPL(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("lrps: same-cycle implication violated");

// trig implies cond in the next cycle
`define LRPS_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("lrps: next-cycle implication violated");

`endif

FILE: rtl/lrps_pkg.sv
// Shared types, constants and helper functions for the LED ring pattern sequencer.
// No dependencies.
package lrps_pkg;

   localparam int unsigned TICKS_PER_UNIT = 10;
   localparam logic [11:0] TICK_MAX       = 12'd4095;
   localparam logic [7:0]  ENDLESS        = 8'hFF;
   localparam logic [6:0]  DUTY_TOP       = 7'd99;
   localparam logic [3:0]  DOUBLE_TOP     = 4'hC;
   localparam logic [3:0]  CHASE_TOP      = 4'h8;
   localparam logic [3:0]  MODE_LIMIT     = 4'd7;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_CMD  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      MODE_ON      = 3'd0,
      MODE_OFF     = 3'd1,
      MODE_BLINK   = 3'd2,
      MODE_BREATHE = 3'd3,
      MODE_CW      = 3'd4,
      MODE_CCW     = 3'd5,
      MODE_DOUBLE  = 3'd6
   } mode_type;

   typedef struct packed {
      op_type      opcode;
      logic [3:0]  cmd_mode;
      logic [7:0]  cmd_count;
      logic [7:0]  cmd_period;
      logic        only_if_changed;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  active_mode;
      logic [3:0]  row_pins;
      logic [6:0]  duty_pct;
      logic        column_pwm_on;
      logic [3:0]  column_pins;
   } rsp_item_type;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  repeat_count;
      logic [7:0]  period;
      logic [11:0] tick_down;
      logic [3:0]  column_step;
      logic [3:0]  row_step;
      logic [7:0]  pass_counter;
      logic [6:0]  duty;
      logic        ramp_up;
      logic [3:0]  column_out;
      logic        pwm_select;
      logic [3:0]  row_out;
   } state_type;

   // column lines accept one-hot, all on or all off
   function automatic logic column_code_ok(input logic [3:0] v);
      return (v == 4'h1) || (v == 4'h2) || (v == 4'h4) || (v == 4'h8) ||
             (v == 4'hF) || (v == 4'h0);
   endfunction

   // row lines additionally accept adjacent pairs
   function automatic logic row_code_ok(input logic [3:0] v);
      return (v == 4'h1) || (v == 4'h2) || (v == 4'h4) || (v == 4'h8) ||
             (v == 4'h3) || (v == 4'h6) || (v == 4'hC) || (v == 4'hF) ||
             (v == 4'h0);
   endfunction

   // period in units to ticks, saturated to the counter range
   function automatic logic [11:0] reload_ticks(input logic [7:0] period);
      logic [15:0] prod;
      prod = 16'(period) * 16'(TICKS_PER_UNIT);
      return (prod > 16'(TICK_MAX)) ? TICK_MAX : prod[11:0];
   endfunction

endpackage

FILE: rtl/lrps_step.sv
// Next-state and result logic for one item of the LED ring pattern sequencer.
// Depends on lrps_pkg.
module lrps_step (
   input  lrps_pkg::state_type    state_i,
   input  lrps_pkg::req_item_type item_i,
   output lrps_pkg::state_type    state_o,
   output lrps_pkg::rsp_item_type result_o
);

   lrps_pkg::state_type s;
   logic                same_skip;
   logic [7:0]          passes;
   lrps_pkg::mode_type  fallback;

   always_comb begin
      s         = state_i;
      same_skip = 1'b0;
      passes    = 8'd0;
      fallback  = lrps_pkg::MODE_ON;

      // item intake: tick counts down, valid command restarts a mode
      if (item_i.opcode == lrps_pkg::OP_TICK) begin
         if (s.tick_down != 12'd0) s.tick_down = s.tick_down - 12'd1;
      end else begin
         same_skip = item_i.only_if_changed && (item_i.cmd_mode == {1'b0, s.mode});
         if ((item_i.cmd_mode < lrps_pkg::MODE_LIMIT) && !same_skip) begin
            s.ramp_up      = 1'b0;
            s.column_step  = 4'h0;
            s.row_step     = 4'h0;
            s.pass_counter = 8'd0;
            s.duty         = 7'd0;
            s.mode         = lrps_pkg::mode_type'(item_i.cmd_mode[2:0]);
            s.repeat_count = item_i.cmd_count;
            s.period       = item_i.cmd_period;
            s.tick_down    = 12'd0;
         end
      end

      // pattern pass
      unique case (s.mode)
         lrps_pkg::MODE_ON: begin
            s.row_out    = 4'hF;
            s.pwm_select = 1'b0;
            s.column_out = 4'hF;
         end
         lrps_pkg::MODE_OFF: begin
            s.pwm_select = 1'b0;
            s.column_out = 4'h0;
            s.row_out    = 4'h0;
         end
         lrps_pkg::MODE_BLINK: begin
            if (s.tick_down == 12'd0) begin
               if (lrps_pkg::row_code_ok(s.column_step)) s.row_out = s.column_step;
               s.pwm_select = 1'b0;
               if (lrps_pkg::column_code_ok(s.column_step)) s.column_out = s.column_step;
               s.column_step = (s.column_step != 4'h0) ? 4'h0 : 4'hF;
               passes   = s.pass_counter;
               fallback = lrps_pkg::MODE_OFF;
               if (passes == s.repeat_count) s.mode = fallback;
               else if (s.repeat_count == lrps_pkg::ENDLESS) s.pass_counter = 8'd0;
               if (s.column_step != 4'h0) s.pass_counter = s.pass_counter + 8'd1;
               s.tick_down = lrps_pkg::reload_ticks(s.period);
            end
         end
         lrps_pkg::MODE_BREATHE: begin
            if (s.tick_down == 12'd0) begin
               if (s.ramp_up) begin
                  s.duty = s.duty + 7'd1;
                  if (s.duty >= lrps_pkg::DUTY_TOP) begin
                     s.ramp_up      = 1'b0;
                     s.pass_counter = s.pass_counter + 8'd1;
                  end
               end else begin
                  // floor at zero, then turn upward
                  if (s.duty != 7'd0) s.duty = s.duty - 7'd1;
                  if (s.duty <= 7'd1) s.ramp_up = 1'b1;
               end
               passes = s.pass_counter;
               if (passes == s.repeat_count) s.mode = fallback;
               else if (s.repeat_count == lrps_pkg::ENDLESS) s.pass_counter = 8'd0;
               s.row_out    = 4'hF;
               s.pwm_select = 1'b1;
               s.tick_down  = 12'(s.period);
            end
         end
         lrps_pkg::MODE_CW: begin
            if (s.tick_down == 12'd0) begin
               s.row_step = ((s.row_step >= lrps_pkg::CHASE_TOP) || (s.row_step == 4'h0)) ?
                            4'h1 : {s.row_step[2:0], 1'b0};
               s.pwm_select = 1'b0;
               s.column_out = 4'hF;
               if (lrps_pkg::row_code_ok(s.row_step)) s.row_out = s.row_step;
               passes = {2'b00, s.pass_counter[7:2]};
               if (passes == s.repeat_count) s.mode = fallback;
               else if (s.repeat_count == lrps_pkg::ENDLESS) s.pass_counter = 8'd0;
               if (s.row_step == lrps_pkg::CHASE_TOP) s.pass_counter = s.pass_counter + 8'd1;
               s.tick_down = lrps_pkg::reload_ticks(s.period);
            end
         end
         lrps_pkg::MODE_CCW: begin
            if (s.tick_down == 12'd0) begin
               s.row_step = ((s.row_step <= 4'h1) || (s.row_step > lrps_pkg::CHASE_TOP)) ?
                            lrps_pkg::CHASE_TOP : {1'b0, s.row_step[3:1]};
               s.pwm_select = 1'b0;
               s.column_out = 4'hF;
               if (lrps_pkg::row_code_ok(s.row_step)) s.row_out = s.row_step;
               passes = {2'b00, s.pass_counter[7:2]};
               if (passes == s.repeat_count) s.mode = fallback;
               else if (s.repeat_count == lrps_pkg::ENDLESS) s.pass_counter = 8'd0;
               if (s.row_step == 4'h1) s.pass_counter = s.pass_counter + 8'd1;
               s.tick_down = lrps_pkg::reload_ticks(s.period);
            end
         end
         lrps_pkg::MODE_DOUBLE: begin
            if (s.tick_down == 12'd0) begin
               if (s.column_step == 4'h0) s.column_step = 4'h1;
               s.row_step = ((s.row_step >= lrps_pkg::DOUBLE_TOP) || (s.row_step == 4'h0)) ?
                            4'h3 : {s.row_step[2:0], 1'b0};
               s.pwm_select = 1'b0;
               if (lrps_pkg::column_code_ok(s.column_step)) s.column_out = s.column_step;
               if (lrps_pkg::row_code_ok(s.row_step)) s.row_out = s.row_step;
               if (s.row_step >= lrps_pkg::DOUBLE_TOP) begin
                  if (s.column_step >= lrps_pkg::CHASE_TOP) begin
                     s.column_step  = 4'h1;
                     s.pass_counter = s.pass_counter + 8'd1;
                  end else begin
                     s.column_step = {s.column_step[2:0], 1'b0};
                  end
               end
               passes = s.pass_counter;
               if (passes == s.repeat_count) s.mode = fallback;
               else if (s.repeat_count == lrps_pkg::ENDLESS) s.pass_counter = 8'd0;
               s.tick_down = lrps_pkg::reload_ticks(s.period);
            end
         end
         default: begin
            // unused mode code: hold everything
         end
      endcase
   end

   assign state_o                = s;
   assign result_o.column_pins   = s.column_out;
   assign result_o.column_pwm_on = s.pwm_select;
   assign result_o.duty_pct      = s.pwm_select ? s.duty : 7'd0;
   assign result_o.row_pins      = s.row_out;
   assign result_o.active_mode   = s.mode;

endmodule

FILE: rtl/led_ring_pattern_sequencer.sv
// LED ring pattern sequencer top level; uses lrps_pkg, lrps_step and the assertion macros.
// A request passes through the input register, then one pass of pattern logic into the
// result register. Throughput one item per clock while no result is held or rsp_tready is high;
// the pattern state loop is a single register stage.
// A held result does not block intake: the input register still takes one more item.
// Reset (synchronous, active high): all-on mode, counters cleared, item registers empty.
module led_ring_pattern_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] cmd_mode, [11:4] cmd_count, [19:12] cmd_period, [20] only_if_changed,
   // [23:21] zero
   input  logic [23:0] req_tdata,
   // [0] opcode (0 tick, 1 mode command)
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] column_pins, [4] column_pwm_on, [11:5] duty_pct, [15:12] row_pins,
   // [18:16] active_mode, [23:19] zero
   output logic [23:0] rsp_tdata
);

`include "led_ring_pattern_sequencer_defines.svh"

   // input register
   logic                   in_valid_ff, in_valid_in;
   lrps_pkg::req_item_type in_item_ff, in_item_in;

   // pattern state
   lrps_pkg::state_type    state_ff, state_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   lrps_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic req_accept;
   logic fire;   // input item moves through the pattern logic this cycle

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_accept = req_tvalid && req_tready;

   // unpack the request
   always_comb begin
      in_item_in.opcode          = lrps_pkg::op_type'(req_tuser);
      in_item_in.cmd_mode        = req_tdata[3:0];
      in_item_in.cmd_count       = req_tdata[11:4];
      in_item_in.cmd_period      = req_tdata[19:12];
      in_item_in.only_if_changed = req_tdata[20];
   end

   assign in_valid_in  = req_accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   lrps_step u_step (
      .state_i  (state_ff),
      .item_i   (in_item_ff),
      .state_o  (state_in),
      .result_o (rsp_item_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) state_ff <= state_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) in_item_ff  <= in_item_in;
      if (fire)       rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_item_ff};

   // checks
   `LRPS_ASSERT_NEXT(a_fire_gives_result, fire, rsp_tvalid)
   `LRPS_ASSERT_IMPL(a_full_stall_blocks, in_valid_ff && rsp_valid_ff && !rsp_tready, !req_tready)
   `LRPS_ASSERT_ALWAYS(a_duty_in_range, state_ff.duty <= lrps_pkg::DUTY_TOP)
   `LRPS_ASSERT_IMPL(a_pwm_off_zero_duty, rsp_tvalid && !rsp_tdata[4], rsp_tdata[11:5] == 7'd0)

endmodule
